FILE: rtl/core/baro_temp_pressure_compensation_top_defines.svh
// Assertion macros shared by the compensation pipeline.
// BTPC_ASSERT is checked only out of reset; BTPC_ASSERT_RST is checked at every edge.
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_TOP_DEFINES_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define BTPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BTPC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BTPC_ASSERT(lbl, prop, msg)
`define BTPC_ASSERT_RST(lbl, prop, msg)
`endif
`endif

FILE: rtl/core/btpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package btpc_pkg;

  // Number of register stages from the input to the output register.
  localparam int NSTG = 9;

  // Calibration register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_SENS       = 3'd0,
    REG_OFFSET     = 3'd1,
    REG_SENS_TC    = 3'd2,
    REG_OFFSET_TC  = 3'd3,
    REG_REF_TEMP   = 3'd4,
    REG_TEMP_SLOPE = 3'd5
  } cfg_reg_t;

  // Per-stage load enables and occupancy, from the control block to the datapath.
  typedef struct packed {
    logic [NSTG-1:0] en;
    logic [NSTG-1:0] vld;
  } pipe_ctl_t;

  // Temperature limits and thresholds, in 0.01 C.
  localparam logic signed [20:0] TEMP_BASE = 21'sd2000;
  localparam logic signed [20:0] TEMP_MIN  = -21'sd4000;
  localparam logic signed [20:0] TEMP_MAX  = 21'sd8500;
  // Offset that moves the low threshold (-15.00 C) onto TEMP-2000.
  localparam logic signed [19:0] LOW_SHIFT = 20'sd3500;
  localparam logic signed [18:0] LOW_LIMIT = -19'sd3500;

  // Pressure limits, in Pa.
  localparam logic signed [32:0] PRES_MIN = 33'sd1000;
  localparam logic signed [32:0] PRES_MAX = 33'sd120000;

endpackage
`default_nettype wire

FILE: rtl/core/btpc_pipe_ctl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "baro_temp_pressure_compensation_top_defines.svh"
module btpc_pipe_ctl
  import btpc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output pipe_ctl_t ctl
);

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] en;

  // A stage loads when it is empty or when the stage after it moves on.
  always_comb begin
    en[NSTG-1] = !vld_r[NSTG-1] || out_ready;
    for (int k = NSTG-2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  // Valid bits travel with the data; a held stage keeps its own.
  always_comb begin
    vld_nxt[0] = en[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NSTG; k++) begin
      vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[NSTG-1];
  assign ctl.en    = en;
  assign ctl.vld   = vld_r;

  // The pipeline refuses input only when every stage holds an item.
  `BTPC_ASSERT(a_full_when_blocked, !en[0] |-> (&vld_r), "input blocked with a free stage")
  // A held first stage keeps its item.
  `BTPC_ASSERT(a_hold_first, (vld_r[0] && !en[0]) |=> vld_r[0], "held item lost in stage 0")
  // The last stage empties only through an output transfer.
  `BTPC_ASSERT(a_drain_by_transfer, $fell(vld_r[NSTG-1]) |-> $past(out_ready),
               "result dropped without transfer")
  // Reset empties the whole pipeline.
  `BTPC_ASSERT_RST(a_reset_empty, !rst_n |=> (vld_r == '0), "pipeline not empty after reset")

endmodule
`default_nettype wire

FILE: rtl/core/baro_temp_pressure_compensation_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake             Payload
// in_       input      in_valid/in_ready     in_raw_pressure, in_raw_temperature
// out_      output     out_valid/out_ready   out_temperature_centi, out_pressure_pa,
//                                            out_out_of_range
// cfg_      input      cfg_valid/cfg_ready   cfg_index, cfg_wdata
//
// Nine register stages: one transfer per cycle in and out while out_ready is high.
// The depth is set by the dT products, the squared temperature terms and the
// 24 x 42 bit pressure product, split into two halves over two stages.
// Reset clears the stage valid bits and the six calibration registers.
// A stalled output holds only the stages behind it that are full; empty stages
// keep filling, so input transfers go on while a result waits.
module baro_temp_pressure_compensation_top
  import btpc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [23:0]        in_raw_pressure,
  input  logic [23:0]        in_raw_temperature,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [14:0] out_temperature_centi,
  output logic [16:0]        out_pressure_pa,
  output logic               out_out_of_range,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata
);

  pipe_ctl_t ctl;

  btpc_pipe_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  // Calibration registers.
  logic [15:0] sens_r, offset_r, sens_tc_r, offset_tc_r, ref_temp_r, temp_slope_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sens_r       <= '0;
      offset_r     <= '0;
      sens_tc_r    <= '0;
      offset_tc_r  <= '0;
      ref_temp_r   <= '0;
      temp_slope_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_SENS:       sens_r       <= cfg_wdata;
        REG_OFFSET:     offset_r     <= cfg_wdata;
        REG_SENS_TC:    sens_tc_r    <= cfg_wdata;
        REG_OFFSET_TC:  offset_tc_r  <= cfg_wdata;
        REG_REF_TEMP:   ref_temp_r   <= cfg_wdata;
        REG_TEMP_SLOPE: temp_slope_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The raw pressure rides along until the pressure product.
  logic [23:0] d1_r [NSTG-3];

  always_ff @(posedge clk) begin
    if (ctl.en[0]) d1_r[0] <= in_raw_pressure;
    for (int k = 1; k < NSTG-3; k++) begin
      if (ctl.en[k]) d1_r[k] <= d1_r[k-1];
    end
  end

  // Stage 0: dT = raw temperature minus the reference.
  logic signed [24:0] dt_r, dt_nxt;
  assign dt_nxt = $signed({1'b0, in_raw_temperature}) - $signed({1'b0, ref_temp_r, 8'h00});

  always_ff @(posedge clk) begin
    if (ctl.en[0]) dt_r <= dt_nxt;
  end

  // Stage 1: the four products of dT.
  logic signed [41:0] mt_r, mo_r, ms_r;
  logic [48:0]        mdd_r;
  logic signed [41:0] mt_nxt, mo_nxt, ms_nxt;
  logic signed [49:0] mdd_full;

  assign mt_nxt   = 42'(dt_r) * 42'($signed({1'b0, temp_slope_r}));
  assign mo_nxt   = 42'(dt_r) * 42'($signed({1'b0, offset_tc_r}));
  assign ms_nxt   = 42'(dt_r) * 42'($signed({1'b0, sens_tc_r}));
  assign mdd_full = 50'(dt_r) * 50'(dt_r);

  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      mt_r  <= mt_nxt;
      mo_r  <= mo_nxt;
      ms_r  <= ms_nxt;
      mdd_r <= mdd_full[48:0];
    end
  end

  // Stage 2: first-order TEMP-2000, OFF, SENS and the T2 term.
  logic signed [18:0] tq2_r;
  logic signed [19:0] tb2_r;
  logic signed [35:0] off2s_r, sens2s_r;
  logic [17:0]        t2_2_r;
  logic signed [35:0] off_nxt, sens_nxt;

  assign off_nxt  = $signed({4'h0, offset_r, 16'h0000}) + 36'($signed(mo_r[41:7]));
  assign sens_nxt = $signed({5'h00, sens_r, 15'h0000}) + 36'($signed(ms_r[41:8]));

  always_ff @(posedge clk) begin
    if (ctl.en[2]) begin
      tq2_r    <= $signed(mt_r[41:23]);
      tb2_r    <= 20'($signed(mt_r[41:23])) + LOW_SHIFT;
      off2s_r  <= off_nxt;
      sens2s_r <= sens_nxt;
      t2_2_r   <= mdd_r[48:31];
    end
  end

  // Stage 3: squares for the second-order terms and the range tests.
  logic [35:0]        sqa3_r, sqb3_r;
  logic               lt20_3_r, lt15_3_r;
  logic signed [18:0] tq3_r;
  logic [17:0]        t2_3_r;
  logic signed [35:0] off3_r, sens3_r;
  logic signed [37:0] sqa_full;
  logic signed [39:0] sqb_full;

  assign sqa_full = 38'(tq2_r) * 38'(tq2_r);
  assign sqb_full = 40'(tb2_r) * 40'(tb2_r);

  always_ff @(posedge clk) begin
    if (ctl.en[3]) begin
      sqa3_r   <= sqa_full[35:0];
      sqb3_r   <= sqb_full[35:0];
      lt20_3_r <= tq2_r[18];
      lt15_3_r <= (tq2_r < LOW_LIMIT);
      tq3_r    <= tq2_r;
      t2_3_r   <= t2_2_r;
      off3_r   <= off2s_r;
      sens3_r  <= sens2s_r;
    end
  end

  // Stage 4: OFF2, SENS2 and the corrected temperature.
  logic [39:0]        off2_4_r, sens2_4_r;
  logic signed [20:0] temp4_r;
  logic signed [35:0] off4_r, sens4_r;
  logic [39:0]        sqa5, sqb7, sqb11, off2_nxt, sens2_nxt;
  logic signed [20:0] temp_nxt;

  always_comb begin
    sqa5  = ({4'h0, sqa3_r} << 2) + {4'h0, sqa3_r};
    sqb7  = ({4'h0, sqb3_r} << 3) - {4'h0, sqb3_r};
    sqb11 = ({4'h0, sqb3_r} << 3) + ({4'h0, sqb3_r} << 1) + {4'h0, sqb3_r};
    off2_nxt  = '0;
    sens2_nxt = '0;
    temp_nxt  = 21'(tq3_r) + TEMP_BASE;
    if (lt20_3_r) begin
      off2_nxt  = (sqa5 >> 1) + (lt15_3_r ? sqb7 : 40'h0);
      sens2_nxt = (sqa5 >> 2) + (lt15_3_r ? (sqb11 >> 1) : 40'h0);
      temp_nxt  = 21'(tq3_r) + TEMP_BASE - $signed({3'b000, t2_3_r});
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[4]) begin
      off2_4_r  <= off2_nxt;
      sens2_4_r <= sens2_nxt;
      temp4_r   <= temp_nxt;
      off4_r    <= off3_r;
      sens4_r   <= sens3_r;
    end
  end

  // Stage 5: final OFF and SENS, temperature saturation.
  logic signed [41:0] off5_r, sens5_r;
  logic signed [14:0] temp5_r;
  logic               tflag5_r;
  logic signed [14:0] temp_sat;
  logic               tflag_nxt;

  always_comb begin
    temp_sat  = temp4_r[14:0];
    tflag_nxt = 1'b0;
    if (temp4_r < TEMP_MIN) begin
      temp_sat  = TEMP_MIN[14:0];
      tflag_nxt = 1'b1;
    end else if (temp4_r > TEMP_MAX) begin
      temp_sat  = TEMP_MAX[14:0];
      tflag_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[5]) begin
      off5_r   <= 42'(off4_r) - $signed({2'b00, off2_4_r});
      sens5_r  <= 42'(sens4_r) - $signed({2'b00, sens2_4_r});
      temp5_r  <= temp_sat;
      tflag5_r <= tflag_nxt;
    end
  end

  // Stage 6: raw pressure times SENS, as two 24 x 21 bit halves.
  logic signed [45:0] phi6_r;
  logic [44:0]        plo6_r;
  logic signed [41:0] off6_r;
  logic signed [14:0] temp6_r;
  logic               tflag6_r;

  always_ff @(posedge clk) begin
    if (ctl.en[6]) begin
      phi6_r   <= 46'($signed({1'b0, d1_r[5]})) * 46'($signed(sens5_r[41:21]));
      plo6_r   <= 45'(d1_r[5]) * 45'(sens5_r[20:0]);
      off6_r   <= off5_r;
      temp6_r  <= temp5_r;
      tflag6_r <= tflag5_r;
    end
  end

  // Stage 7: (D1*SENS >> 21) - OFF; the low half adds in shifted.
  logic signed [47:0] x7_r;
  logic signed [14:0] temp7_r;
  logic               tflag7_r;

  always_ff @(posedge clk) begin
    if (ctl.en[7]) begin
      x7_r     <= 48'(phi6_r) + $signed({24'h000000, plo6_r[44:21]}) - 48'(off6_r);
      temp7_r  <= temp6_r;
      tflag7_r <= tflag6_r;
    end
  end

  // Stage 8: final shift, pressure saturation, output register.
  logic signed [32:0] pres;
  logic [16:0]        pres_sat;
  logic               pflag;

  assign pres = x7_r[47:15];

  always_comb begin
    pres_sat = pres[16:0];
    pflag    = 1'b0;
    if (pres < PRES_MIN) begin
      pres_sat = PRES_MIN[16:0];
      pflag    = 1'b1;
    end else if (pres > PRES_MAX) begin
      pres_sat = PRES_MAX[16:0];
      pflag    = 1'b1;
    end
  end

  logic signed [14:0] temp_out_r;
  logic [16:0]        pres_out_r;
  logic               flag_out_r;

  always_ff @(posedge clk) begin
    if (ctl.en[8]) begin
      temp_out_r <= temp7_r;
      pres_out_r <= pres_sat;
      flag_out_r <= tflag7_r | pflag;
    end
  end

  assign out_temperature_centi = temp_out_r;
  assign out_pressure_pa       = pres_out_r;
  assign out_out_of_range      = flag_out_r;

endmodule
`default_nettype wire
